// File: design/ucrh_pkg.sv
`timescale 1ns / 1ps

package ucrh_pkg;

    localparam int PACKET_BYTES  = 8;
    localparam int NUM_ENDPOINTS = 4;
    localparam int EP_IDX_W      = $clog2(NUM_ENDPOINTS);
    localparam int PC_W          = $clog2(PACKET_BYTES);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W         = 6;

    localparam logic [PC_W-1:0] PKT_LAST = PC_W'(PACKET_BYTES - 1);

    localparam logic [CNT_W-1:0] LEN_DEVICE = 6'd18;
    localparam logic [CNT_W-1:0] LEN_CONFIG = 6'd32;
    localparam logic [CNT_W-1:0] LEN_LANG   = 6'd4;
    localparam logic [CNT_W-1:0] LEN_SERIAL = 6'd26;
    localparam logic [CNT_W-1:0] LEN_ONE    = 6'd1;
    localparam logic [CNT_W-1:0] LEN_PAIR   = 6'd2;

    // {bRequest, bmRequestType}
    localparam logic [15:0] RQ_GET_DESCRIPTOR = 16'h0680;
    localparam logic [15:0] RQ_SET_ADDRESS    = 16'h0500;
    localparam logic [15:0] RQ_SET_CONFIG     = 16'h0900;
    localparam logic [15:0] RQ_GET_CONFIG     = 16'h0880;
    localparam logic [15:0] RQ_STATUS_DEVICE  = 16'h0080;
    localparam logic [15:0] RQ_STATUS_IFACE   = 16'h0081;
    localparam logic [15:0] RQ_STATUS_EP      = 16'h0082;
    localparam logic [15:0] RQ_SETF_IFACE     = 16'h0301;
    localparam logic [15:0] RQ_SETF_EP        = 16'h0302;
    localparam logic [15:0] RQ_CLRF_IFACE     = 16'h0101;
    localparam logic [15:0] RQ_CLRF_EP        = 16'h0102;

    localparam logic [15:0] DESC_DEVICE    = 16'h0100;
    localparam logic [15:0] DESC_CONFIG    = 16'h0200;
    localparam logic [15:0] DESC_TYPE_MASK = 16'h0F00;
    localparam logic [15:0] DESC_STRING    = 16'h0300;
    localparam logic [7:0]  STR_LANG       = 8'h00;
    localparam logic [7:0]  STR_SERIAL     = 8'h01;

    localparam logic [NUM_ENDPOINTS-1:0] EP0_BIT     = NUM_ENDPOINTS'(1);
    localparam logic [NUM_ENDPOINTS-1:0] EP_CFG_BITS = NUM_ENDPOINTS'(6);

    typedef enum logic [1:0] {
        FN_SETUP     = 2'd0,
        FN_BUS_RESET = 2'd1,
        FN_SUSPEND   = 2'd2,
        FN_RESUME    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_ZLP   = 2'd1,
        KIND_STALL = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CS_UNCONFIGURED = 2'd0,
        CS_CONFIGURED   = 2'd1,
        CS_SUSPENDED    = 2'd2
    } t_cfg_state;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_ZLP,
        OP_STALL,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        SRC_DEVICE,
        SRC_CONFIG,
        SRC_LANG,
        SRC_SERIAL,
        SRC_LIT
    } t_src;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_DATA,
        ST_TAIL
    } t_back_state;

    typedef struct packed {
        logic [6:0] addr;
        logic       addr_en;
        logic [1:0] cfg_state;
        logic [7:0] cfg_value;
    } t_status;

    typedef struct packed {
        t_op             op;
        t_src            src;
        logic [7:0]      lit;
        logic [CNT_W-1:0] count;
        logic            tail_zlp;
        t_status         st;
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       pend;
        logic       last;
        t_status    st;
    } t_result;

    function automatic logic [7:0] rom_device(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:  b = 8'h12;
            6'd1:  b = 8'h01;
            6'd3:  b = 8'h02;
            6'd7:  b = 8'h08;
            6'd8:  b = 8'h94;
            6'd9:  b = 8'h06;
            6'd10: b = 8'h02;
            6'd16: b = 8'h01;
            6'd17: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] rom_config(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:  b = 8'h09;
            6'd1:  b = 8'h02;
            6'd2:  b = 8'h20;
            6'd4:  b = 8'h01;
            6'd5:  b = 8'h01;
            6'd7:  b = 8'hC0;
            6'd9:  b = 8'h09;
            6'd10: b = 8'h04;
            6'd13: b = 8'h02;
            6'd14: b = 8'hFF;
            6'd15: b = 8'hFF;
            6'd16: b = 8'hFF;
            6'd18: b = 8'h07;
            6'd19: b = 8'h05;
            6'd20: b = 8'h01;
            6'd21: b = 8'h02;
            6'd22: b = 8'h40;
            6'd25: b = 8'h07;
            6'd26: b = 8'h05;
            6'd27: b = 8'h82;
            6'd28: b = 8'h02;
            6'd29: b = 8'h40;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] rom_serial(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:  b = 8'h1A;
            6'd1:  b = 8'h03;
            6'd2:  b = 8'h31;
            6'd4:  b = 8'h32;
            6'd6:  b = 8'h33;
            6'd8:  b = 8'h34;
            6'd10: b = 8'h35;
            6'd12: b = 8'h36;
            6'd14: b = 8'h37;
            6'd16: b = 8'h38;
            6'd18: b = 8'h30;
            6'd20: b = 8'h30;
            6'd22: b = 8'h39;
            6'd24: b = 8'h30;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] rom_lang(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0: b = 8'h04;
            6'd1: b = 8'h03;
            6'd2: b = 8'h09;
            6'd3: b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] src_byte(input t_src src, input logic [CNT_W-1:0] idx,
                                            input logic [7:0] lit);
        logic [7:0] b;
        case (src)
            SRC_DEVICE: b = rom_device(idx);
            SRC_CONFIG: b = rom_config(idx);
            SRC_LANG:   b = rom_lang(idx);
            SRC_SERIAL: b = rom_serial(idx);
            SRC_LIT:    b = (idx == '0) ? lit : 8'h00;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: design/ucrh_front.sv
`timescale 1ns / 1ps

module ucrh_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    input  logic [63:0]          i_word,
    output logic                 o_q_push,
    input  logic                 i_q_full,
    output ucrh_pkg::t_cmd       o_cmd
);

    logic [1:0]                           r_cfg_state, n_cfg_state;
    logic [7:0]                           r_cfg_value, n_cfg_value;
    logic [6:0]                           r_addr, n_addr;
    logic                                 r_aen, n_aen;
    logic                                 r_cfgbit, n_cfgbit;
    logic [ucrh_pkg::NUM_ENDPOINTS-1:0]   r_ep_en, n_ep_en;

    logic [15:0]                   req, val, len;
    logic [3:0]                    ep;
    logic [ucrh_pkg::EP_IDX_W-1:0] ep_idx;
    logic [ucrh_pkg::NUM_ENDPOINTS-1:0] ep_bit;
    logic                          ep_ok, ep_in_range;
    logic                          accept;
    ucrh_pkg::t_func               func;
    ucrh_pkg::t_cmd                cmd;

    assign req    = {i_word[15:8], i_word[7:0]};
    assign val    = i_word[31:16];
    assign ep     = i_word[35:32];
    assign len    = i_word[63:48];
    assign func   = ucrh_pkg::t_func'(i_func);
    assign ep_idx = ep[ucrh_pkg::EP_IDX_W-1:0];
    assign ep_bit = ucrh_pkg::EP0_BIT << ep_idx;
    assign ep_in_range = (ep < 4'(ucrh_pkg::NUM_ENDPOINTS));
    assign ep_ok  = (val == 16'h0000) && (ep != 4'd0) && ep_in_range;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign o_q_push = accept;

    always_comb begin
        n_cfg_state  = r_cfg_state;
        n_cfg_value  = r_cfg_value;
        n_addr       = r_addr;
        n_aen        = r_aen;
        n_cfgbit     = r_cfgbit;
        n_ep_en      = r_ep_en;
        cmd.op       = ucrh_pkg::OP_STALL;
        cmd.src      = ucrh_pkg::SRC_LIT;
        cmd.lit      = 8'h00;
        cmd.count    = ucrh_pkg::LEN_ONE;
        cmd.tail_zlp = 1'b0;
        case (func)
            ucrh_pkg::FN_SETUP: begin
                case (req)
                    ucrh_pkg::RQ_GET_DESCRIPTOR: begin
                        if (val == ucrh_pkg::DESC_DEVICE) begin
                            cmd.op    = ucrh_pkg::OP_DATA;
                            cmd.src   = ucrh_pkg::SRC_DEVICE;
                            cmd.count = ucrh_pkg::LEN_DEVICE;
                        end else if (val == ucrh_pkg::DESC_CONFIG) begin
                            if (len == 16'd0) begin
                                cmd.op = ucrh_pkg::OP_ZLP;
                            end else begin
                                cmd.op       = ucrh_pkg::OP_DATA;
                                cmd.src      = ucrh_pkg::SRC_CONFIG;
                                cmd.count    = (len < 16'd32) ? len[ucrh_pkg::CNT_W-1:0]
                                                              : ucrh_pkg::LEN_CONFIG;
                                cmd.tail_zlp = (len > 16'd32);
                            end
                        end else if ((val & ucrh_pkg::DESC_TYPE_MASK) ==
                                     ucrh_pkg::DESC_STRING) begin
                            if (val[7:0] == ucrh_pkg::STR_LANG) begin
                                cmd.op    = ucrh_pkg::OP_DATA;
                                cmd.src   = ucrh_pkg::SRC_LANG;
                                cmd.count = ucrh_pkg::LEN_LANG;
                            end else if (val[7:0] == ucrh_pkg::STR_SERIAL) begin
                                cmd.op    = ucrh_pkg::OP_DATA;
                                cmd.src   = ucrh_pkg::SRC_SERIAL;
                                cmd.count = ucrh_pkg::LEN_SERIAL;
                            end
                        end
                    end
                    ucrh_pkg::RQ_SET_ADDRESS: begin
                        cmd.op   = ucrh_pkg::OP_ZLP;
                        n_addr   = val[6:0];
                        n_aen    = (val != 16'h0000);
                        n_cfgbit = 1'b0;
                    end
                    ucrh_pkg::RQ_SET_CONFIG: begin
                        cmd.op      = ucrh_pkg::OP_ZLP;
                        n_cfg_state = ucrh_pkg::CS_CONFIGURED;
                        n_cfg_value = val[7:0];
                        n_cfgbit    = (val != 16'h0000);
                        n_aen       = (val == 16'h0000);
                        n_ep_en     = (r_ep_en & ucrh_pkg::EP0_BIT) |
                                      ((val != 16'h0000) ? ucrh_pkg::EP_CFG_BITS : '0);
                    end
                    ucrh_pkg::RQ_SETF_EP: begin
                        if (ep_ok) begin
                            cmd.op  = ucrh_pkg::OP_ZLP;
                            n_ep_en = r_ep_en & ~ep_bit;
                        end
                    end
                    ucrh_pkg::RQ_CLRF_EP: begin
                        if (ep_ok) begin
                            cmd.op  = ucrh_pkg::OP_ZLP;
                            n_ep_en = r_ep_en | ep_bit;
                        end
                    end
                    ucrh_pkg::RQ_GET_CONFIG: begin
                        cmd.op    = ucrh_pkg::OP_DATA;
                        cmd.lit   = r_cfg_value;
                        cmd.count = ucrh_pkg::LEN_ONE;
                    end
                    ucrh_pkg::RQ_STATUS_DEVICE: begin
                        cmd.op    = ucrh_pkg::OP_DATA;
                        cmd.lit   = 8'h01;
                        cmd.count = ucrh_pkg::LEN_PAIR;
                    end
                    ucrh_pkg::RQ_STATUS_IFACE: begin
                        cmd.op    = ucrh_pkg::OP_DATA;
                        cmd.count = ucrh_pkg::LEN_PAIR;
                    end
                    ucrh_pkg::RQ_STATUS_EP: begin
                        if (r_cfgbit && ep_in_range) begin
                            cmd.op    = ucrh_pkg::OP_DATA;
                            cmd.count = ucrh_pkg::LEN_PAIR;
                            cmd.lit   = (ep == 4'd0) ? 8'h00 : {7'd0, ~r_ep_en[ep_idx]};
                        end else if (r_aen && (ep == 4'd0)) begin
                            cmd.op    = ucrh_pkg::OP_DATA;
                            cmd.count = ucrh_pkg::LEN_PAIR;
                            cmd.lit   = {7'd0, ~r_ep_en[0]};
                        end
                    end
                    ucrh_pkg::RQ_SETF_IFACE, ucrh_pkg::RQ_CLRF_IFACE: begin
                        cmd.op = ucrh_pkg::OP_ZLP;
                    end
                    default: begin
                        cmd.op = ucrh_pkg::OP_STALL;
                    end
                endcase
            end
            ucrh_pkg::FN_BUS_RESET: begin
                cmd.op      = ucrh_pkg::OP_NONE;
                n_cfg_state = ucrh_pkg::CS_UNCONFIGURED;
                n_cfg_value = 8'h00;
                n_addr      = 7'd0;
                n_aen       = 1'b0;
                n_cfgbit    = 1'b0;
                n_ep_en     = ucrh_pkg::EP0_BIT;
            end
            ucrh_pkg::FN_SUSPEND: begin
                cmd.op      = ucrh_pkg::OP_NONE;
                n_cfg_state = (r_cfg_state == ucrh_pkg::CS_CONFIGURED) ?
                              ucrh_pkg::CS_SUSPENDED : ucrh_pkg::CS_UNCONFIGURED;
            end
            ucrh_pkg::FN_RESUME: begin
                cmd.op      = ucrh_pkg::OP_NONE;
                n_cfg_state = (r_cfg_state == ucrh_pkg::CS_SUSPENDED) ?
                              ucrh_pkg::CS_CONFIGURED : ucrh_pkg::CS_UNCONFIGURED;
            end
            default: begin
                cmd.op = ucrh_pkg::OP_NONE;
            end
        endcase
        cmd.st.addr      = n_addr;
        cmd.st.addr_en   = n_aen;
        cmd.st.cfg_state = n_cfg_state;
        cmd.st.cfg_value = n_cfg_value;
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_state <= ucrh_pkg::CS_UNCONFIGURED;
            r_cfg_value <= 8'h00;
            r_addr      <= 7'd0;
            r_aen       <= 1'b0;
            r_cfgbit    <= 1'b0;
            r_ep_en     <= ucrh_pkg::EP0_BIT;
        end else if (accept) begin
            r_cfg_state <= n_cfg_state;
            r_cfg_value <= n_cfg_value;
            r_addr      <= n_addr;
            r_aen       <= n_aen;
            r_cfgbit    <= n_cfgbit;
            r_ep_en     <= n_ep_en;
        end
    end

endmodule

// File: design/ucrh_cmd_queue.sv
`timescale 1ns / 1ps

module ucrh_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  ucrh_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  logic              i_pop,
    output ucrh_pkg::t_cmd    o_cmd
);

    ucrh_pkg::t_cmd              r_mem [ucrh_pkg::QUEUE_DEPTH];
    logic [ucrh_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [ucrh_pkg::QCNT_W-1:0] r_cnt;
    logic                        full, do_push, do_pop;

    localparam logic [ucrh_pkg::QPTR_W-1:0] PTR_LAST =
        ucrh_pkg::QPTR_W'(ucrh_pkg::QUEUE_DEPTH - 1);
    localparam logic [ucrh_pkg::QCNT_W-1:0] CNT_FULL =
        ucrh_pkg::QCNT_W'(ucrh_pkg::QUEUE_DEPTH);

    assign full    = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rp];

    assign o_full = full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/ucrh_back.sv
`timescale 1ns / 1ps

module ucrh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ucrh_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output ucrh_pkg::t_result o_res
);

    ucrh_pkg::t_back_state         r_state, n_state;
    ucrh_pkg::t_cmd                r_cmd, n_cmd;
    logic [ucrh_pkg::CNT_W-1:0]    r_idx, n_idx, idx_next;
    logic [ucrh_pkg::PC_W-1:0]     r_pc, n_pc;
    logic                          r_valid, n_valid;
    ucrh_pkg::t_result             r_res, n_res;
    logic                          can_emit, final_byte;

    assign can_emit   = !r_valid || i_ready;
    assign idx_next   = r_idx + 1'b1;
    assign final_byte = (idx_next == r_cmd.count);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        n_pc    = r_pc;
        n_valid = r_valid && !i_ready;
        n_res   = r_res;
        o_q_pop = 1'b0;
        case (r_state)
            ucrh_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    n_pc    = '0;
                    n_state = (i_q_cmd.op == ucrh_pkg::OP_DATA) ? ucrh_pkg::ST_DATA
                                                                 : ucrh_pkg::ST_SINGLE;
                end
            end
            ucrh_pkg::ST_SINGLE: begin
                if (can_emit) begin
                    n_valid    = 1'b1;
                    n_res.data = 8'h00;
                    n_res.last = 1'b1;
                    n_res.st   = r_cmd.st;
                    case (r_cmd.op)
                        ucrh_pkg::OP_ZLP: begin
                            n_res.kind = ucrh_pkg::KIND_ZLP;
                            n_res.pend = 1'b1;
                        end
                        ucrh_pkg::OP_STALL: begin
                            n_res.kind = ucrh_pkg::KIND_STALL;
                            n_res.pend = 1'b0;
                        end
                        default: begin
                            n_res.kind = ucrh_pkg::KIND_NONE;
                            n_res.pend = 1'b0;
                        end
                    endcase
                    n_state = ucrh_pkg::ST_IDLE;
                end
            end
            ucrh_pkg::ST_DATA: begin
                if (can_emit) begin
                    n_valid    = 1'b1;
                    n_res.kind = ucrh_pkg::KIND_DATA;
                    n_res.data = ucrh_pkg::src_byte(r_cmd.src, r_idx, r_cmd.lit);
                    n_res.pend = (r_pc == ucrh_pkg::PKT_LAST) || final_byte;
                    n_res.last = final_byte && !r_cmd.tail_zlp;
                    n_res.st   = r_cmd.st;
                    n_idx      = idx_next;
                    n_pc       = (r_pc == ucrh_pkg::PKT_LAST) ? '0 : r_pc + 1'b1;
                    if (final_byte) begin
                        n_state = r_cmd.tail_zlp ? ucrh_pkg::ST_TAIL : ucrh_pkg::ST_IDLE;
                    end
                end
            end
            ucrh_pkg::ST_TAIL: begin
                if (can_emit) begin
                    n_valid    = 1'b1;
                    n_res.kind = ucrh_pkg::KIND_ZLP;
                    n_res.data = 8'h00;
                    n_res.pend = 1'b1;
                    n_res.last = 1'b1;
                    n_res.st   = r_cmd.st;
                    n_state    = ucrh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ucrh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucrh_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_pc  <= n_pc;
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: design/usb_control_request_handler_core.sv
`timescale 1ns / 1ps
// An accepted event word is written into the command queue, popped by the back end in
// its idle state, and its first result word is registered on the output.
// Throughput: one result word per cycle while the sink is ready; a reply is up to 33 words.
// A two-entry command queue lets the front take events while replies stream out.
// Reset: synchronous active low; clears device state, queue and output valid.

module usb_control_request_handler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // request_type[7:0], request_code[15:8], value_word[31:16],
    // index_word[47:32], length_word[63:48]
    input  logic [63:0] i_s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // data_byte[7:0], device_address[14:8], address_enabled[15],
    // configured_state[17:16], current_config[25:18], zero[31:26]
    output logic [31:0] o_m_axis_tdata,
    // kind[1:0], packet_end[2]
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    logic              q_push, q_full;
    ucrh_pkg::t_cmd    front_cmd, q_cmd;
    logic              q_valid, q_pop;
    ucrh_pkg::t_result res;

    ucrh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_func   (i_s_axis_tuser),
        .i_word   (i_s_axis_tdata),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_cmd    (front_cmd)
    );

    ucrh_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_cmd   (front_cmd),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    ucrh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (res)
    );

    assign o_m_axis_tdata = {6'd0, res.st.cfg_value, res.st.cfg_state, res.st.addr_en,
                             res.st.addr, res.data};
    assign o_m_axis_tuser = {res.pend, res.kind};
    assign o_m_axis_tlast = res.last;

endmodule

// File: design/ucrh_checker.sv
`timescale 1ns / 1ps

module ucrh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    logic non_data, single_kind;

    assign non_data    = (o_m_axis_tuser[1:0] != ucrh_pkg::KIND_DATA);
    assign single_kind = (o_m_axis_tuser[1:0] == ucrh_pkg::KIND_STALL) ||
                         (o_m_axis_tuser[1:0] == ucrh_pkg::KIND_NONE);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid &&
        $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && non_data |-> (o_m_axis_tdata[7:0] == 8'h00))
        else $error("non-data word carries a data byte");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && single_kind |-> o_m_axis_tlast && !o_m_axis_tuser[2])
        else $error("stall or no-transfer word not a lone final word");

    a_zlp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == ucrh_pkg::KIND_ZLP) |->
        o_m_axis_tuser[2])
        else $error("zero-length packet without packet end");

    a_cfg_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[17:16] != 2'd3))
        else $error("configured state out of range");

endmodule

bind usb_control_request_handler_core ucrh_checker u_ucrh_checker (.*);
